// ===== design/vbt_pkg.sv =====
package vbt_pkg;

    // Field widths.
    localparam int CYCLE_W   = 11;
    localparam int LINE_W    = 9;
    localparam int DOT_W     = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Segment lengths in master cycles.
    localparam logic [CYCLE_W-1:0] VIS_CYCLES = 11'd1024;
    localparam logic [CYCLE_W-1:0] HBL_CYCLES = 11'd336;
    localparam logic [CYCLE_W-1:0] VBL_CYCLES = 11'd1360;

    localparam logic [LINE_W-1:0] LAST_VIS_LINE = 9'h0E0;
    localparam logic [LINE_W-1:0] WRAP_LINE     = 9'h106;
    localparam logic [DOT_W-1:0]  DOT_HBLANK    = 9'd256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IRQ_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_H_COMPARE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_V_COMPARE = 2'd2;

    typedef enum logic [1:0] {
        PH_VISIBLE,
        PH_HBLANK,
        PH_VBLANK,
        PH_HB_VB
    } phase_t;

    typedef enum logic [1:0] {
        IRQ_OFF,
        IRQ_H,
        IRQ_V,
        IRQ_HV
    } irq_mode_t;

    typedef struct packed {
        logic [CYCLE_W-1:0] cycle;
        logic [LINE_W-1:0]  line;
        logic [DOT_W-1:0]   dot;
        phase_t             phase;
    } beam_state_t;

    typedef struct packed {
        irq_mode_t          irq_mode;
        logic [DOT_W-1:0]   h_compare;
        logic [LINE_W-1:0]  v_compare;
    } beam_cfg_t;

    typedef struct packed {
        logic               hblank_begin;
        logic               vblank_start;
        logic               frame_begin;
        logic               timer_irq;
        logic [LINE_W-1:0]  line;
        logic [DOT_W-1:0]   dot;
        phase_t             phase;
    } beam_result_t;

endpackage

// ===== design/vbt_channels.sv =====
interface vbt_tick_if
    import vbt_pkg::*;
();
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface vbt_beam_if
    import vbt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              hblank_begin;
    logic              vblank_start;
    logic              frame_begin;
    logic              timer_irq;
    logic [LINE_W-1:0] line_now;
    logic [DOT_W-1:0]  dot_now;
    logic [1:0]        phase_now;

    modport source (
        output valid, output hblank_begin, output vblank_start, output frame_begin,
        output timer_irq, output line_now, output dot_now, output phase_now,
        input ready
    );
    modport sink (
        input valid, input hblank_begin, input vblank_start, input frame_begin,
        input timer_irq, input line_now, input dot_now, input phase_now,
        output ready
    );
endinterface

// ===== design/vbt_step.sv =====
module vbt_step
    import vbt_pkg::*;
(
    input  beam_state_t  state,
    input  beam_cfg_t    cfg,
    input  logic         tick,
    output beam_state_t  state_next,
    output beam_result_t result
);

    // One master cycle of beam timing, evaluated combinationally.
    always_comb
    begin
        logic [CYCLE_W-1:0] cycle_inc;
        logic [LINE_W-1:0]  line_inc;
        logic               h_hit;
        logic               v_hit;

        cycle_inc  = state.cycle + 1'b1;
        line_inc   = state.line + 1'b1;
        state_next = state;
        result     = '0;
        h_hit      = 1'b0;
        v_hit      = 1'b0;

        if (tick)
        begin
            state_next.cycle = cycle_inc;
            unique case (state.phase)
                PH_VISIBLE:
                begin
                    state_next.dot = cycle_inc[CYCLE_W-1:2];
                    if (cycle_inc >= VIS_CYCLES)
                    begin
                        state_next.cycle    = cycle_inc - VIS_CYCLES;
                        state_next.phase    = PH_HBLANK;
                        result.hblank_begin = 1'b1;
                    end
                end
                PH_HBLANK:
                begin
                    if (cycle_inc >= HBL_CYCLES)
                    begin
                        state_next.cycle = cycle_inc - HBL_CYCLES;
                        state_next.line  = line_inc;
                        state_next.dot   = '0;
                        if (line_inc <= LAST_VIS_LINE)
                        begin
                            state_next.phase = PH_VISIBLE;
                        end
                        else
                        begin
                            state_next.phase    = PH_VBLANK;
                            result.vblank_start = 1'b1;
                        end
                    end
                end
                PH_VBLANK, PH_HB_VB:
                begin
                    state_next.phase = (state.line <= LAST_VIS_LINE) ? PH_VBLANK : PH_HB_VB;
                    if (cycle_inc >= VBL_CYCLES)
                    begin
                        state_next.cycle = cycle_inc - VBL_CYCLES;
                        state_next.line  = line_inc;
                        state_next.dot   = '0;
                        if (line_inc >= WRAP_LINE)
                        begin
                            state_next.phase   = PH_VISIBLE;
                            state_next.line    = '0;
                            result.frame_begin = 1'b1;
                        end
                    end
                end
            endcase

            // Compares look at the beam position after this cycle.
            h_hit = (state_next.dot == cfg.h_compare);
            v_hit = (state_next.line == cfg.v_compare);
            unique case (cfg.irq_mode)
                IRQ_OFF: result.timer_irq = 1'b0;
                IRQ_H:   result.timer_irq = h_hit;
                IRQ_V:   result.timer_irq = v_hit && (state_next.dot == '0);
                IRQ_HV:  result.timer_irq = h_hit && v_hit;
            endcase
        end

        result.line  = state_next.line;
        result.dot   = state_next.dot;
        result.phase = state_next.phase;
    end

endmodule

// ===== design/video_beam_timing_irq.sv =====
// Channel    | Role   | Payload
// -----------+--------+----------------------------------------------------------
// tick_chan  | sink   | tick: one master cycle passes when 1
// beam_chan  | source | hblank_begin, vblank_start, frame_begin, timer_irq,
//            |        | line_now, dot_now, phase_now
// cfg port   | write  | cfg_we, cfg_index, cfg_data (irq_mode, h_compare, v_compare)
//
// Every tick beat yields exactly one beam beat via the input and result registers.
// Unless both stages are full and the output is held, a new tick beat is taken every
// cycle and throughput is one beat per clock, set by the combinational state update.
// Reset clears the beam counters, the configuration and both valid flags.
// A stalled result register holds its beat and back-pressures the input stage
// only when both stages are full.

module video_beam_timing_irq
    import vbt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    vbt_tick_if.sink             tick_chan,
    vbt_beam_if.source           beam_chan,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Input stage: one registered tick beat.
    logic         in_valid_reg;
    logic         tick_reg;

    // Beam state and configuration.
    beam_state_t  state_reg;
    beam_state_t  state_next;
    beam_cfg_t    cfg_reg;

    // Result stage.
    logic         out_valid_reg;
    beam_result_t result_reg;
    beam_result_t result_next;

    logic         out_free;
    logic         advance;

    // The result register can take a new beat when it is empty or being drained.
    assign out_free        = !out_valid_reg || beam_chan.ready;
    // The beam state is loaded exactly when a registered tick beat moves to the result.
    assign advance         = in_valid_reg && out_free;
    assign tick_chan.ready = !in_valid_reg || out_free;

    vbt_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .tick       (tick_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick_chan.ready)
        begin
            in_valid_reg <= tick_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_chan.ready && tick_chan.valid)
        begin
            tick_reg <= tick_chan.tick;
        end
    end

    // Beam counters advance one master cycle per consumed beat whose tick is 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{cycle: '0, line: '0, dot: '0, phase: PH_VISIBLE};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{irq_mode: IRQ_OFF, h_compare: '0, v_compare: '0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IRQ_MODE:  cfg_reg.irq_mode  <= irq_mode_t'(cfg_data[1:0]);
                REG_H_COMPARE: cfg_reg.h_compare <= cfg_data;
                REG_V_COMPARE: cfg_reg.v_compare <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign beam_chan.valid        = out_valid_reg;
    assign beam_chan.hblank_begin = result_reg.hblank_begin;
    assign beam_chan.vblank_start = result_reg.vblank_start;
    assign beam_chan.frame_begin  = result_reg.frame_begin;
    assign beam_chan.timer_irq    = result_reg.timer_irq;
    assign beam_chan.line_now     = result_reg.line;
    assign beam_chan.dot_now      = result_reg.dot;
    assign beam_chan.phase_now    = result_reg.phase;

`ifndef ASSERT_OFF
    // In plain hblank the dot is parked at the end of the visible line.
    a_hblank_dot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_HBLANK |-> state_reg.dot == DOT_HBLANK)
        else $error("dot position left its hblank value");

    // The cycle counter never reaches the longest segment length.
    a_cycle_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cycle < VBL_CYCLES)
        else $error("cycle counter out of range");

    // A frame start always lands on line zero in the visible phase.
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.frame_begin |->
            result_reg.line == '0 && result_reg.phase == PH_VISIBLE)
        else $error("frame start without wrap to line zero");

    // The input stalls only when both stages hold a beat and the output is held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_chan.ready |-> in_valid_reg && out_valid_reg && !beam_chan.ready)
        else $error("input stalled without output back-pressure");
`endif

endmodule
